FILE: hw/rtl/pvpsm_pkg.sv
package pvpsm_pkg;

   // Store geometry
   localparam int MAX_SITES    = 256;
   localparam int MAX_CLASSES  = 32;
   localparam int MAX_FRAGMENT = 16;
   localparam int STORE_DEPTH  = MAX_SITES * MAX_CLASSES;

   // Field widths
   localparam int ACTION_W    = 2;
   localparam int SITE_IDX_W  = 8;
   localparam int CLASS_IDX_W = 5;
   localparam int PROB_W      = 16;
   localparam int ROW_W       = 9;
   localparam int SCORE_W     = 40;
   localparam int PROD_W      = 2 * PROB_W;

   // Register widths
   localparam int CC_W  = 6;
   localparam int FL_W  = 5;
   localparam int SC_W  = 9;
   localparam int APB_W = 32;
   localparam int PADDR_W = 4;

   // Derived internal widths
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int M_W    = $clog2(MAX_CLASSES + 1);
   localparam int K_W    = $clog2(MAX_FRAGMENT + 1);
   localparam int S_W    = $clog2(MAX_SITES + 1);
   localparam int DIM_RAW_W = $clog2(MAX_SITES + MAX_FRAGMENT + 2);
   localparam int DIM_W  = (DIM_RAW_W > ROW_W) ? DIM_RAW_W : ROW_W;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_WRITE_FIRST  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE_SECOND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY        = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR        = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_CLASS_COUNT       = 2'd0;
   localparam logic [1:0] REG_FRAGMENT_LENGTH   = 2'd1;
   localparam logic [1:0] REG_FIRST_SITE_COUNT  = 2'd2;
   localparam logic [1:0] REG_SECOND_SITE_COUNT = 2'd3;

   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctrl_type;

endpackage

FILE: hw/rtl/probvec_pair_score_matrix_top.sv
// Pair score matrix over two stores of class-probability vectors.
// Request channel (req_*): action selects write first store, write second
// store, query a cell (req_row, req_col) or clear both stores. Every request
// yields exactly one response on the rsp_* channel: score (Q8.32) and
// out_of_range; writes and clears answer with zero.
// Handshake: a beat moves on an edge where valid is high and stall is low.
// Request handling: writes and out-of-range queries post their response
// directly; an in-range query steps through fragment_length diagonal
// offsets and runs class_count products for each of the T site pairs
// inside both sets; a clear is a zero sweep over both stores.
// Queries run on one multiply-accumulate unit fed by a single read
// port per store, one class element per cycle, under the query sequencer.
// One request at a time: req_stall stays high until the response is posted.
// A posted response waits in the output register while rsp_stall is high;
// the next request is accepted meanwhile.
// Reset restores the register defaults and runs the same zero sweep
// with req_stall high; APB writes are taken throughout.
module probvec_pair_score_matrix_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pvpsm_pkg::ACTION_W-1:0]       req_action,
   input  logic [pvpsm_pkg::SITE_IDX_W-1:0]     req_site_index,
   input  logic [pvpsm_pkg::CLASS_IDX_W-1:0]    req_class_index,
   input  logic [pvpsm_pkg::PROB_W-1:0]         req_prob_value,
   input  logic [pvpsm_pkg::ROW_W-1:0]          req_row,
   input  logic [pvpsm_pkg::ROW_W-1:0]          req_col,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pvpsm_pkg::SCORE_W-1:0]        rsp_score,
   output logic                                 rsp_out_of_range,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pvpsm_pkg::PADDR_W-1:0]        paddr,
   input  logic [pvpsm_pkg::APB_W-1:0]          pwdata,
   output logic [pvpsm_pkg::APB_W-1:0]          prdata,
   output logic                                 pready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_KSETUP = 3'd2;
   localparam logic [2:0] ST_MAC    = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam logic [1:0] DRAIN_LAST = 2'd2;

   localparam int ADDR_W = pvpsm_pkg::ADDR_W;
   localparam int M_W    = pvpsm_pkg::M_W;
   localparam int K_W    = pvpsm_pkg::K_W;
   localparam int S_W    = pvpsm_pkg::S_W;
   localparam int DIM_W  = pvpsm_pkg::DIM_W;

   // configuration registers
   logic [pvpsm_pkg::CC_W-1:0]  class_count_ff,  class_count_in;
   logic [pvpsm_pkg::FL_W-1:0]  frag_len_ff,     frag_len_in;
   logic [pvpsm_pkg::SC_W-1:0]  first_cnt_ff,    first_cnt_in;
   logic [pvpsm_pkg::SC_W-1:0]  second_cnt_ff,   second_cnt_in;

   // sequencer
   logic [2:0]                  state_ff,    state_in;
   logic [ADDR_W-1:0]           clr_cnt_ff,  clr_cnt_in;
   logic                        clr_reply_ff, clr_reply_in;
   logic [K_W-1:0]              k_ff,        k_in;
   logic [M_W-1:0]              m_ff,        m_in;
   logic [pvpsm_pkg::ROW_W-1:0] row_ff,      row_in;
   logic [pvpsm_pkg::ROW_W-1:0] col_ff,      col_in;
   logic [M_W-1:0]              nc_ff,       nc_in;
   logic [K_W-1:0]              fl_ff,       fl_in;
   logic [S_W-1:0]              s1_ff,       s1_in;
   logic [S_W-1:0]              s2_ff,       s2_in;
   logic [ADDR_W-1:0]           base_a_ff,   base_a_in;
   logic [ADDR_W-1:0]           base_b_ff,   base_b_in;
   logic [1:0]                  drain_ff,    drain_in;
   logic                        is_query_ff, is_query_in;
   logic                        oor_ff,      oor_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pvpsm_pkg::SCORE_W-1:0]  rsp_score_ff, rsp_score_in;
   logic                           rsp_oor_ff,   rsp_oor_in;
   logic                           rsp_load;

   // clamped configuration
   logic [M_W-1:0]   nc_cl;
   logic [K_W-1:0]   fl_cl;
   logic [S_W-1:0]   s1_cl;
   logic [S_W-1:0]   s2_cl;
   logic [DIM_W-1:0] n_rows;
   logic [DIM_W-1:0] n_cols;
   logic             req_oor;

   logic                    accept;
   logic                    in_store;
   logic [ADDR_W-1:0]       req_addr;
   logic                    clearing;
   logic                    wr_first, wr_second;
   logic [ADDR_W-1:0]       wr_addr;
   logic [pvpsm_pkg::PROB_W-1:0] wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b;
   logic [pvpsm_pkg::PROB_W-1:0] rd_data_a, rd_data_b;
   logic [pvpsm_pkg::SCORE_W-1:0] acc;
   pvpsm_pkg::mac_ctrl_type mac_ctrl;

   logic [DIM_W-1:0]        site_a, site_b;
   logic                    term_ok;
   logic                    cfg_wr;

   // clamp registers above their bounds
   always_comb begin
      nc_cl = (32'(class_count_ff) > pvpsm_pkg::MAX_CLASSES) ?
              M_W'(pvpsm_pkg::MAX_CLASSES) : M_W'(class_count_ff);
      fl_cl = (32'(frag_len_ff) > pvpsm_pkg::MAX_FRAGMENT) ?
              K_W'(pvpsm_pkg::MAX_FRAGMENT) : K_W'(frag_len_ff);
      s1_cl = (32'(first_cnt_ff) > pvpsm_pkg::MAX_SITES) ?
              S_W'(pvpsm_pkg::MAX_SITES) : S_W'(first_cnt_ff);
      s2_cl = (32'(second_cnt_ff) > pvpsm_pkg::MAX_SITES) ?
              S_W'(pvpsm_pkg::MAX_SITES) : S_W'(second_cnt_ff);
      n_rows  = DIM_W'(s1_cl) + DIM_W'(fl_cl) + DIM_W'(1);
      n_cols  = DIM_W'(s2_cl) + DIM_W'(fl_cl) + DIM_W'(1);
      req_oor = (DIM_W'(req_row) >= n_rows) || (DIM_W'(req_col) >= n_cols);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // element address of a write; indexes past the store are dropped
   assign in_store = (32'(req_site_index) < pvpsm_pkg::MAX_SITES) &&
                     (32'(req_class_index) < pvpsm_pkg::MAX_CLASSES);
   assign req_addr = ADDR_W'(32'(req_site_index) * pvpsm_pkg::MAX_CLASSES +
                             32'(req_class_index));

   // site pair for the current diagonal offset
   always_comb begin
      site_a  = DIM_W'(row_ff) - DIM_W'(k_ff) - DIM_W'(1);
      site_b  = DIM_W'(col_ff) - DIM_W'(k_ff) - DIM_W'(1);
      term_ok = (DIM_W'(row_ff) > DIM_W'(k_ff)) && (DIM_W'(col_ff) > DIM_W'(k_ff)) &&
                (site_a < DIM_W'(s1_ff)) && (site_b < DIM_W'(s2_ff)) &&
                (nc_ff != '0);
   end

   // shared write port: zero sweep or request write
   always_comb begin
      clearing  = (state_ff == ST_CLEAR);
      wr_first  = clearing ||
                  (accept && (req_action == pvpsm_pkg::ACT_WRITE_FIRST) && in_store);
      wr_second = clearing ||
                  (accept && (req_action == pvpsm_pkg::ACT_WRITE_SECOND) && in_store);
      wr_addr   = clearing ? clr_cnt_ff : req_addr;
      wr_data   = clearing ? '0 : req_prob_value;
   end

   always_comb begin
      rd_en          = (state_ff == ST_MAC);
      rd_addr_a      = base_a_ff + ADDR_W'(m_ff);
      rd_addr_b      = base_b_ff + ADDR_W'(m_ff);
      mac_ctrl.issue = rd_en;
      mac_ctrl.clear = accept && (req_action == pvpsm_pkg::ACT_QUERY);
   end

   pvpsm_store first_store (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   pvpsm_store second_store (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   pvpsm_mac mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .a_data (rd_data_a),
      .b_data (rd_data_b),
      .acc    (acc)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_reply_in = clr_reply_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      nc_in        = nc_ff;
      fl_in        = fl_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      base_a_in    = base_a_ff;
      base_b_in    = base_b_ff;
      drain_in     = drain_ff;
      is_query_in  = is_query_ff;
      oor_in       = oor_ff;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               is_query_in = 1'b0;
               oor_in      = 1'b0;
               case (req_action)
                  pvpsm_pkg::ACT_CLEAR: begin
                     clr_cnt_in   = '0;
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  pvpsm_pkg::ACT_QUERY: begin
                     if (req_oor) begin
                        oor_in   = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        // latch the clamped setup for the whole query
                        is_query_in = 1'b1;
                        row_in      = req_row;
                        col_in      = req_col;
                        nc_in       = nc_cl;
                        fl_in       = fl_cl;
                        s1_in       = s1_cl;
                        s2_in       = s2_cl;
                        k_in        = '0;
                        state_in    = ST_KSETUP;
                     end
                  end
                  default: begin
                     // element writes land at this edge
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(pvpsm_pkg::STORE_DEPTH - 1)) begin
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_KSETUP: begin
            if (k_ff == fl_ff) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else if (term_ok) begin
               base_a_in = ADDR_W'(32'(site_a) * pvpsm_pkg::MAX_CLASSES);
               base_b_in = ADDR_W'(32'(site_b) * pvpsm_pkg::MAX_CLASSES);
               m_in      = '0;
               state_in  = ST_MAC;
            end else begin
               // pair outside a set: skip this offset
               k_in = k_ff + K_W'(1);
            end
         end
         ST_MAC: begin
            m_in = m_ff + M_W'(1);
            if (m_ff == nc_ff - M_W'(1)) begin
               k_in     = k_ff + K_W'(1);
               state_in = ST_KSETUP;
            end
         end
         ST_DRAIN: begin
            // let the last products reach the accumulator
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_score_in = is_query_ff ? acc : '0;
         rsp_oor_in   = oor_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration port
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      class_count_in = class_count_ff;
      frag_len_in    = frag_len_ff;
      first_cnt_in   = first_cnt_ff;
      second_cnt_in  = second_cnt_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            pvpsm_pkg::REG_CLASS_COUNT:      class_count_in = pwdata[pvpsm_pkg::CC_W-1:0];
            pvpsm_pkg::REG_FRAGMENT_LENGTH:  frag_len_in    = pwdata[pvpsm_pkg::FL_W-1:0];
            pvpsm_pkg::REG_FIRST_SITE_COUNT: first_cnt_in   = pwdata[pvpsm_pkg::SC_W-1:0];
            default:                         second_cnt_in  = pwdata[pvpsm_pkg::SC_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         pvpsm_pkg::REG_CLASS_COUNT:      prdata = pvpsm_pkg::APB_W'(class_count_ff);
         pvpsm_pkg::REG_FRAGMENT_LENGTH:  prdata = pvpsm_pkg::APB_W'(frag_len_ff);
         pvpsm_pkg::REG_FIRST_SITE_COUNT: prdata = pvpsm_pkg::APB_W'(first_cnt_ff);
         default:                         prdata = pvpsm_pkg::APB_W'(second_cnt_ff);
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         clr_reply_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         class_count_ff <= pvpsm_pkg::CC_W'(32);
         frag_len_ff    <= pvpsm_pkg::FL_W'(1);
         first_cnt_ff   <= pvpsm_pkg::SC_W'(256);
         second_cnt_ff  <= pvpsm_pkg::SC_W'(256);
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         clr_reply_ff   <= clr_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
         class_count_ff <= class_count_in;
         frag_len_ff    <= frag_len_in;
         first_cnt_ff   <= first_cnt_in;
         second_cnt_ff  <= second_cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      m_ff        <= m_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      nc_ff       <= nc_in;
      fl_ff       <= fl_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      base_a_ff   <= base_a_in;
      base_b_ff   <= base_b_in;
      drain_ff    <= drain_in;
      is_query_ff <= is_query_in;
      oor_ff      <= oor_in;
      rsp_score_ff <= rsp_score_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

FILE: hw/rtl/pvpsm_store.sv
module pvpsm_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [pvpsm_pkg::ADDR_W-1:0]       wr_addr,
   input  logic [pvpsm_pkg::PROB_W-1:0]       wr_data,
   input  logic                               rd_en,
   input  logic [pvpsm_pkg::ADDR_W-1:0]       rd_addr,
   output logic [pvpsm_pkg::PROB_W-1:0]       rd_data
);

   logic [pvpsm_pkg::PROB_W-1:0] store_ff [pvpsm_pkg::STORE_DEPTH];
   logic [pvpsm_pkg::PROB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pvpsm_mac.sv
module pvpsm_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  pvpsm_pkg::mac_ctrl_type           ctrl,
   input  logic [pvpsm_pkg::PROB_W-1:0]      a_data,
   input  logic [pvpsm_pkg::PROB_W-1:0]      b_data,
   output logic [pvpsm_pkg::SCORE_W-1:0]     acc
);

   logic                               data_vld_ff;
   logic                               prod_vld_ff;
   logic [pvpsm_pkg::PROD_W-1:0]       prod_ff;
   logic [pvpsm_pkg::PROD_W-1:0]       prod_in;
   logic [pvpsm_pkg::SCORE_W-1:0]      acc_ff;
   logic [pvpsm_pkg::SCORE_W-1:0]      acc_in;
   logic [pvpsm_pkg::SCORE_W:0]        sum;

   always_comb begin
      prod_in = a_data * b_data;
      sum     = {1'b0, acc_ff} + {{(pvpsm_pkg::SCORE_W + 1 - pvpsm_pkg::PROD_W){1'b0}}, prod_ff};
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         // saturate at the top of the score range
         acc_in = sum[pvpsm_pkg::SCORE_W] ? pvpsm_pkg::SCORE_MAX
                                          : sum[pvpsm_pkg::SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         data_vld_ff <= ctrl.issue;
         prod_vld_ff <= data_vld_ff;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (data_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: tb/sv/tb_probvec_pair_score_matrix_top.sv
`timescale 1ns / 1ps

module tb_probvec_pair_score_matrix_top;
   import pvpsm_pkg::*;

   // Run length and safety limits
   localparam int ITEM_TARGET  = 1170;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
   localparam int DRAIN_TAIL   = 600;   // slowest query plus margin
   localparam int RANDOM_CLEARS = 8;    // each clear sweeps both stores

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               out_of_range;
   } score_rsp_t;

   typedef enum int {FLOW_FREE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

   // Mirror of the two vector stores and the four registers. Every accepted
   // request lands here and queues the response it must produce.
   class cell_score_tracker;
      logic [PROB_W-1:0] first_store [STORE_DEPTH];
      logic [PROB_W-1:0] second_store [STORE_DEPTH];
      logic [CC_W-1:0]   class_count;
      logic [FL_W-1:0]   fragment_length;
      logic [SC_W-1:0]   first_sites;
      logic [SC_W-1:0]   second_sites;
      score_rsp_t        pending_scores [$];
      int                mismatches;

      function new();
         clear_stores();
         class_count     = CC_W'(32);
         fragment_length = FL_W'(1);
         first_sites     = SC_W'(256);
         second_sites    = SC_W'(256);
         mismatches      = 0;
      endfunction

      function void clear_stores();
         foreach (first_store[i]) begin
            first_store[i]  = '0;
            second_store[i] = '0;
         end
      endfunction

      function int bounded(int value, int ceiling);
         return (value > ceiling) ? ceiling : value;
      endfunction

      function int active_classes();
         return bounded(class_count, MAX_CLASSES);
      endfunction

      function int active_first();
         return bounded(first_sites, MAX_SITES);
      endfunction

      function int active_second();
         return bounded(second_sites, MAX_SITES);
      endfunction

      function int matrix_rows();
         return active_first() + bounded(fragment_length, MAX_FRAGMENT) + 1;
      endfunction

      function int matrix_cols();
         return active_second() + bounded(fragment_length, MAX_FRAGMENT) + 1;
      endfunction

      function void set_register(logic [1:0] idx, logic [APB_W-1:0] value);
         case (idx)
            REG_CLASS_COUNT:       class_count     = value[CC_W-1:0];
            REG_FRAGMENT_LENGTH:   fragment_length = value[FL_W-1:0];
            REG_FIRST_SITE_COUNT:  first_sites     = value[SC_W-1:0];
            REG_SECOND_SITE_COUNT: second_sites    = value[SC_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [APB_W-1:0] register_value(logic [1:0] idx);
         case (idx)
            REG_CLASS_COUNT:       return APB_W'(class_count);
            REG_FRAGMENT_LENGTH:   return APB_W'(fragment_length);
            REG_FIRST_SITE_COUNT:  return APB_W'(first_sites);
            default:               return APB_W'(second_sites);
         endcase
      endfunction

      // Sum the diagonal run of dot products ending at (row, col)
      function logic [SCORE_W-1:0] cell_score(int row, int col);
         int nc, fl, s1, s2, a, b;
         longint unsigned acc, lhs, rhs;
         nc  = active_classes();
         fl  = bounded(fragment_length, MAX_FRAGMENT);
         s1  = active_first();
         s2  = active_second();
         acc = 0;
         for (int k = 0; k < fl; k++) begin
            if (row < k + 1 || col < k + 1) break;
            a = row - 1 - k;
            b = col - 1 - k;
            if (a >= s1 || b >= s2) continue;
            for (int m = 0; m < nc; m++) begin
               lhs = first_store[a * MAX_CLASSES + m];
               rhs = second_store[b * MAX_CLASSES + m];
               acc += lhs * rhs;
            end
         end
         if (acc > SCORE_MAX) return SCORE_MAX;
         return acc[SCORE_W-1:0];
      endfunction

      function void note_request(logic [ACTION_W-1:0] action, logic [SITE_IDX_W-1:0] site,
                                 logic [CLASS_IDX_W-1:0] cls, logic [PROB_W-1:0] prob,
                                 logic [ROW_W-1:0] row, logic [ROW_W-1:0] col);
         score_rsp_t want;
         int addr;
         want = '0;
         addr = site * MAX_CLASSES + cls;
         case (action)
            ACT_WRITE_FIRST:  first_store[addr]  = prob;
            ACT_WRITE_SECOND: second_store[addr] = prob;
            ACT_CLEAR:        clear_stores();
            default: begin
               if (row >= matrix_rows() || col >= matrix_cols())
                  want.out_of_range = 1'b1;
               else
                  want.score = cell_score(row, col);
            end
         endcase
         pending_scores.push_back(want);
      endfunction

      function void check_response(logic [SCORE_W-1:0] score, logic out_of_range);
         score_rsp_t want;
         if (pending_scores.size() == 0) begin
            $error("unexpected response: score %0h out_of_range %0b", score, out_of_range);
            mismatches++;
            return;
         end
         want = pending_scores.pop_front();
         if (score !== want.score) begin
            $error("score: expected %0h actual %0h", want.score, score);
            mismatches++;
         end
         if (out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b actual %0b", want.out_of_range, out_of_range);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ACTION_W-1:0]     req_action;
   logic [SITE_IDX_W-1:0]   req_site_index;
   logic [CLASS_IDX_W-1:0]  req_class_index;
   logic [PROB_W-1:0]       req_prob_value;
   logic [ROW_W-1:0]        req_row;
   logic [ROW_W-1:0]        req_col;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [SCORE_W-1:0]      rsp_score;
   logic                    rsp_out_of_range;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [PADDR_W-1:0]      paddr;
   logic [APB_W-1:0]        pwdata;
   logic [APB_W-1:0]        prdata;
   logic                    pready;

   cell_score_tracker tracker;
   int                cycle_count = 0;
   int                requests_sent = 0;
   int                burst_left = 0;
   int                clears_left = RANDOM_CLEARS;
   int                holds_asked = 0;
   int                csr_errors = 0;
   string             reg_names [4] = '{"class_count", "fragment_length",
                                        "first_site_count", "second_site_count"};

   probvec_pair_score_matrix_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_site_index   (req_site_index),
      .req_class_index  (req_class_index),
      .req_prob_value   (req_prob_value),
      .req_row          (req_row),
      .req_col          (req_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_score        (rsp_score),
      .rsp_out_of_range (rsp_out_of_range),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   // Count cycles for the watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Abort a hung run.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Check every response that moves; stall is our own, driven at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_score, rsp_out_of_range);
   end

   // Receiver: switch to a new random stall style when the current one ends, and serve
   // each long hold-off the stimulus asks for by counting cycles here.
   initial begin : response_side
      stall_style_e style;
      int style_left, hold_left, holds_served;
      rsp_stall    = 1'b0;
      style        = FLOW_FREE;
      style_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_served < holds_asked) begin
            hold_left = LONG_HOLD;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (style_left == 0) begin
               style      = stall_style_e'($urandom_range(0, 3));
               style_left = $urandom_range(32, 256);
            end
            style_left--;
            case (style)
               FLOW_FREE:   rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((style_left % 5) < 2);
            endcase
         end
      end
   end

   // Present one request and hold it until the block takes it. Between bursts,
   // drop valid for a random gap.
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [SITE_IDX_W-1:0] site,
                               input logic [CLASS_IDX_W-1:0] cls,
                               input logic [PROB_W-1:0] prob,
                               input logic [ROW_W-1:0] row,
                               input logic [ROW_W-1:0] col);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= action;
      req_site_index  <= site;
      req_class_index <= cls;
      req_prob_value  <= prob;
      req_row         <= row;
      req_col         <= col;
      do @(posedge clock); while (req_stall);
      tracker.note_request(action, site, cls, prob, row, col);
      requests_sent++;
   endtask

   // Drop valid and wait until every queued response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending_scores.size() != 0) @(posedge clock);
   endtask

   task automatic check_register(input logic [1:0] idx);
      logic [APB_W-1:0] want;
      want = tracker.register_value(idx);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $error("%s: expected %0h actual %0h", reg_names[idx], want, prdata);
         csr_errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [APB_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_register(idx);
   endtask

   // Reprogram all four registers once the block has gone idle.
   task automatic configure(input int cc, input int fl, input int s1, input int s2);
      drain_responses();
      write_register(REG_CLASS_COUNT, APB_W'(cc));
      write_register(REG_FRAGMENT_LENGTH, APB_W'(fl));
      write_register(REG_FIRST_SITE_COUNT, APB_W'(s1));
      write_register(REG_SECOND_SITE_COUNT, APB_W'(s2));
   endtask

   // Mostly writes into the live part of the sets and queries over the matrix
   // plus its first outside row and column; a share of pure noise on top.
   task automatic send_random_request();
      int unsigned pick, span, nc;
      logic [ACTION_W-1:0]    action;
      logic [SITE_IDX_W-1:0]  site;
      logic [CLASS_IDX_W-1:0] cls;
      logic [PROB_W-1:0]      prob;
      logic [ROW_W-1:0]       row, col;
      pick = $urandom_range(0, 199);
      if (pick < 2 && clears_left > 0) begin
         action = ACT_CLEAR;
         clears_left--;
      end else if (pick < 80) begin
         action = ACT_WRITE_FIRST;
      end else if (pick < 150) begin
         action = ACT_WRITE_SECOND;
      end else begin
         action = ACT_QUERY;
      end
      span = (action == ACT_WRITE_FIRST) ? tracker.active_first() : tracker.active_second();
      if (span == 0) span = 1;
      nc = tracker.active_classes();
      if (nc == 0) nc = 1;
      site = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
      cls  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, nc - 1);
      case ($urandom_range(0, 9))
         0:       prob = 16'hFFFF;
         1:       prob = 16'h0000;
         default: prob = $urandom_range(0, 65535);
      endcase
      row = $urandom_range(0, 511);
      col = $urandom_range(0, 511);
      if (action == ACT_QUERY && $urandom_range(0, 4) != 0) begin
         row = $urandom_range(0, tracker.matrix_rows());
         col = $urandom_range(0, tracker.matrix_cols());
      end
      send_request(action, site, cls, prob, row, col);
   endtask

   task automatic run_random_items(input int count);
      repeat (count) send_random_request();
   endtask

   initial begin : stimulus
      int cc, fl, s1, s2, chunk;
      tracker         = new();
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_WRITE_FIRST;
      req_site_index  = '0;
      req_class_index = '0;
      req_prob_value  = '0;
      req_row         = '0;
      req_col         = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults must read back while the zero sweep runs.
      for (int i = 0; i < 4; i++) check_register(2'(i));

      // Directed: corner sites and classes at full scale, alternating bit
      // patterns, the border, the last row/column inside and just outside.
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd0,   9'd0);
      send_request(ACT_WRITE_FIRST,  8'd0,   5'd0,  16'hFFFF, 9'd0,   9'd0);
      send_request(ACT_WRITE_SECOND, 8'd0,   5'd0,  16'hFFFF, 9'd0,   9'd0);
      send_request(ACT_WRITE_FIRST,  8'd255, 5'd31, 16'hFFFF, 9'h1FF, 9'h1FF);
      send_request(ACT_WRITE_SECOND, 8'd255, 5'd31, 16'hFFFF, 9'h1FF, 9'h1FF);
      send_request(ACT_WRITE_FIRST,  8'hAA,  5'h15, 16'h5555, 9'h0AA, 9'h155);
      send_request(ACT_WRITE_SECOND, 8'hAA,  5'h15, 16'hAAAA, 9'h155, 9'h0AA);
      send_request(ACT_WRITE_FIRST,  8'h55,  5'h0A, 16'h0001, 9'd0,   9'd0);
      send_request(ACT_WRITE_SECOND, 8'h55,  5'h0A, 16'h8000, 9'd0,   9'd0);
      send_request(ACT_WRITE_FIRST,  8'd1,   5'd0,  16'h0000, 9'd0,   9'd0);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd1,   9'd1);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd256, 9'd256);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd171, 9'd171);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd86,  9'd86);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd2,   9'd2);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd0,   9'd5);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd5,   9'd0);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd257, 9'd257);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd258, 9'd1);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd1,   9'd258);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd511, 9'd511);
      send_request(ACT_CLEAR,        8'd0,   5'd0,  16'h0000, 9'd0,   9'd0);
      send_request(ACT_QUERY,        8'd0,   5'd0,  16'h0000, 9'd1,   9'd1);

      // Saturation: fill nine sites of both sets near full scale, then query
      // on and around the diagonal at full class count and fragment length. Hold off
      // the receiver meanwhile so the stream of writes backs up.
      configure(32, 16, 256, 256);
      holds_asked++;
      for (int site = 0; site < 9; site++) begin
         for (int cls = 0; cls < 32; cls++) begin
            send_request(ACT_WRITE_FIRST, 8'(site), 5'(cls),
                         16'($urandom_range(16'hF800, 16'hFFFF)), 9'd0, 9'd0);
            send_request(ACT_WRITE_SECOND, 8'(site), 5'(cls),
                         16'($urandom_range(16'hF800, 16'hFFFF)), 9'd0, 9'd0);
         end
      end
      send_request(ACT_QUERY, 8'd0, 5'd0, 16'h0000, 9'd9, 9'd9);
      send_request(ACT_QUERY, 8'd0, 5'd0, 16'h0000, 9'd16, 9'd16);
      send_request(ACT_QUERY, 8'd0, 5'd0, 16'h0000, 9'd9, 9'd10);
      repeat (9)
         send_request(ACT_QUERY, 8'd0, 5'd0, 16'h0000,
                      9'($urandom_range(6, 30)), 9'($urandom_range(6, 30)));

      // Low extremes: one class, one site per set, unit fragment.
      configure(1, 1, 1, 1);
      run_random_items(60);

      // Zero registers: only the corner cell is left, and it scores zero.
      configure(0, 0, 0, 0);
      run_random_items(30);

      // Every register above its bound; the block must saturate each.
      configure(63, 31, 511, 511);
      holds_asked++;
      run_random_items(60);

      // Random settings, mostly small sets so queries land on written sites.
      while (requests_sent < ITEM_TARGET) begin
         cc = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(1, 32);
         fl = $urandom_range(1, 16);
         s1 = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 24);
         s2 = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 24);
         configure(cc, fl, s1, s2);
         if ($urandom_range(0, 2) == 0) holds_asked++;
         chunk = $urandom_range(50, 120);
         if (chunk > ITEM_TARGET - requests_sent) chunk = ITEM_TARGET - requests_sent;
         run_random_items(chunk);
      end

      drain_responses();
      repeat (DRAIN_TAIL) @(posedge clock);

      if (tracker.mismatches == 0 && csr_errors == 0 && tracker.pending_scores.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
